// File: hw/rtl/scfl_pkg.sv
// ----------------------------------------------------------------------------
// scfl_pkg
// Types, constants and codes shared by the size-class free-list allocator.
// ----------------------------------------------------------------------------
package scfl_pkg;

	// Geometry of the size-class cache
	localparam int SIZE_CLASSES    = 64;
	localparam int CLASS_DEPTH     = 10;
	localparam int ADDRESS_BITS    = 48;
	localparam int MAP_LIMIT_BYTES = 128 * 1024;

	// Chunk layout
	localparam int PAGE_BYTES    = 4096;
	localparam int MIN_CHUNK     = 'h20;
	localparam int HDR_BYTES     = 'h10;
	localparam int CLASS_STEP    = 'h10;
	localparam int LARGEST_CLASS = (SIZE_CLASSES - 1) * CLASS_STEP + MIN_CHUNK;

	localparam logic [63:0] FLAG_BITS     = 64'hF;
	localparam logic [63:0] MAPPED_BIT    = 64'h2;
	localparam logic [63:0] PREV_USED_BIT = 64'h1;

	// Field widths
	localparam int REQ_W   = 40;
	localparam int MAP_W   = 40;
	localparam int WORD_W  = 64;
	localparam int ADDR_W  = ADDRESS_BITS;
	localparam int CHUNK_W = $clog2(LARGEST_CLASS + 1);
	localparam int CALC_W  = REQ_W + 2;

	// Memory geometry
	localparam int CLS_W       = (SIZE_CLASSES > 1) ? $clog2(SIZE_CLASSES) : 1;
	localparam int FILL_W      = $clog2(CLASS_DEPTH + 1);
	localparam int STACK_DEPTH = SIZE_CLASSES * CLASS_DEPTH;
	localparam int STACK_AW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

	localparam int CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SECRET_KEY = 2'd0,
		REG_HEAP_BASE  = 2'd1,
		REG_HEAP_LIMIT = 2'd2
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_BIN       = 4'd0,
		ST_HEAP      = 4'd1,
		ST_MAP       = 4'd2,
		ST_UNSUP     = 4'd3,
		ST_BINNED    = 4'd4,
		ST_DROP      = 4'd5,
		ST_UNMAP     = 4'd6,
		ST_BADCOOKIE = 4'd7,
		ST_OOH       = 4'd8,
		ST_NULL      = 4'd9
	} status_t;

	typedef struct packed {
		logic              func;
		logic [REQ_W-1:0]  request_bytes;
		logic [ADDR_W-1:0] user_address;
		logic [WORD_W-1:0] header_word;
		logic [WORD_W-1:0] cookie_word;
	} req_t;

	typedef struct packed {
		status_t           status;
		logic [ADDR_W-1:0] result_address;
		logic [MAP_W-1:0]  map_bytes;
		logic [WORD_W-1:0] size_word_out;
		logic [WORD_W-1:0] cookie_out;
	} rsp_t;

	// What remains to be done after decode
	typedef enum logic [1:0] {
		OP_DONE = 2'd0,
		OP_POP  = 2'd1,
		OP_PUSH = 2'd2
	} op_t;

	typedef struct packed {
		op_t                op;
		logic [CLS_W-1:0]   cls;
		logic [CHUNK_W-1:0] chunk;
		logic [ADDR_W-1:0]  addr;
		rsp_t               res;
	} dec_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'd0,
		S_FILL = 2'd1,
		S_POP  = 2'd2,
		S_OUT  = 2'd3
	} state_t;

endpackage

// File: hw/rtl/size_class_free_list_allocator.sv
// ----------------------------------------------------------------------------
// size_class_free_list_allocator
// Allocate/free engine with per-size-class LIFO caches and a bump heap.
// ----------------------------------------------------------------------------
// One request is handled at a time. An accepted request reads its class fill
// counter at the accept edge; the next cycle updates the counter and reads or
// writes the bin stack; a pop from a non-empty bin then passes through S_POP
// for the stack read data; S_OUT moves the result into the output register
// once that register is free. The next request is taken the cycle after the
// result is registered, while that result may still wait for its transfer.
// The fill-counter memory and the stack memory have registered read ports.
// Configuration writes are always ready; write them only while the engine is
// idle. Writing heap_base clears its low four bits and moves the carve pointer
// to it. Freed chunks are kept in an on-chip stack of CLASS_DEPTH entries per
// class; a free beyond that is dropped.
// ----------------------------------------------------------------------------
module size_class_free_list_allocator (
	input  logic                            clk,
	input  logic                            arst_n,
	// request channel
	input  logic                            req_valid,
	output logic                            req_ready,
	input  scfl_pkg::req_t                  req,
	// result channel
	output logic                            rsp_valid,
	input  logic                            rsp_ready,
	output scfl_pkg::rsp_t                  rsp,
	// configuration write channel
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [scfl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [63:0]                     cfg_data
);
	import scfl_pkg::*;

	// configuration registers and heap pointer
	logic [63:0]       secret_key_q;
	logic [ADDR_W-1:0] heap_limit_q;
	logic [ADDR_W-1:0] heap_top_q;

	// control and per-request state
	state_t state_q, state_d;
	dec_t   dec;
	dec_t   dec_q;
	rsp_t   res_d, res_q;
	rsp_t   rsp_q;
	logic   rsp_valid_q;

	logic req_fire, cfg_fire, out_free;

	// memory ports
	logic [FILL_W-1:0]   fill_rd;
	logic                fill_we;
	logic [FILL_W-1:0]   fill_wdata;
	logic                stk_we, stk_re;
	logic [STACK_AW-1:0] stk_base, stk_addr;
	logic [ADDR_W-1:0]   stk_rdata;

	// heap carve
	logic              heap_oob;
	logic              heap_we;
	logic [ADDR_W-1:0] heap_next;

	assign req_ready = (state_q == S_IDLE);
	assign req_fire  = req_valid && req_ready;
	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid && cfg_ready;
	assign out_free  = !rsp_valid_q || rsp_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	scfl_decode u_decode (
		.req        (req),
		.secret_key (secret_key_q),
		.dec        (dec)
	);

	// fill counter read goes out at the accept edge
	scfl_fill_table u_fill (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (req_fire),
		.rd_addr (dec.cls),
		.rd_data (fill_rd),
		.wr_en   (fill_we),
		.wr_addr (dec_q.cls),
		.wr_data (fill_wdata)
	);

	scfl_stack_ram u_stack (
		.clk     (clk),
		.wr_en   (stk_we),
		.wr_addr (stk_addr),
		.wr_data (dec_q.addr),
		.rd_en   (stk_re),
		.rd_addr (stk_addr),
		.rd_data (stk_rdata)
	);

	// row base of this class in the stack memory
	assign stk_base  = STACK_AW'(dec_q.cls) * STACK_AW'(CLASS_DEPTH);
	assign heap_oob  = (heap_top_q > heap_limit_q)
		|| (ADDR_W'(dec_q.chunk) > (heap_limit_q - heap_top_q));
	assign heap_next = heap_top_q + ADDR_W'(dec_q.chunk);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_fire) state_d = S_FILL;
			end
			S_FILL: begin
				// pop from a non-empty bin waits for the stack read data
				if ((dec_q.op == OP_POP) && (fill_rd != '0)) state_d = S_POP;
				else state_d = S_OUT;
			end
			S_POP: begin
				state_d = S_OUT;
			end
			S_OUT: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// memory updates and result forming
	always_comb begin
		fill_we    = 1'b0;
		fill_wdata = fill_rd;
		stk_we     = 1'b0;
		stk_re     = 1'b0;
		stk_addr   = stk_base + STACK_AW'(fill_rd);
		heap_we    = 1'b0;
		res_d      = dec_q.res;
		unique case (state_q)
			S_FILL: begin
				case (dec_q.op)
					OP_POP: begin
						if (fill_rd != '0) begin
							// take the top entry of the bin
							fill_we    = 1'b1;
							fill_wdata = fill_rd - 1'b1;
							stk_re     = 1'b1;
							stk_addr   = stk_base + STACK_AW'(fill_rd - 1'b1);
						end else if (heap_oob) begin
							res_d.status = ST_OOH;
						end else begin
							// carve from the heap
							heap_we              = 1'b1;
							res_d.status         = ST_HEAP;
							res_d.result_address = heap_top_q + ADDR_W'(HDR_BYTES);
							res_d.size_word_out  = WORD_W'(dec_q.chunk) | PREV_USED_BIT;
						end
					end
					OP_PUSH: begin
						if (fill_rd < FILL_W'(CLASS_DEPTH)) begin
							fill_we      = 1'b1;
							fill_wdata   = fill_rd + 1'b1;
							stk_we       = 1'b1;
							res_d.status = ST_BINNED;
						end else begin
							res_d.status = ST_DROP;
						end
					end
					default: begin
					end
				endcase
			end
			S_POP: begin
				res_d.status         = ST_BIN;
				res_d.result_address = stk_rdata;
				res_d.size_word_out  = WORD_W'(dec_q.chunk) | PREV_USED_BIT;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// hold the decoded request and the pending result
	always_ff @(posedge clk) begin
		if (req_fire) dec_q <= dec;
		if ((state_q == S_FILL) || (state_q == S_POP)) res_q <= res_d;
	end

	// output register: load when free, drop valid on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if ((state_q == S_OUT) && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_OUT) && out_free) rsp_q <= res_q;
	end

	// configuration registers and carve pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			secret_key_q <= '0;
			heap_limit_q <= '1;
			heap_top_q   <= '0;
		end else begin
			if (cfg_fire) begin
				case (cfg_index)
					REG_SECRET_KEY: secret_key_q <= cfg_data;
					REG_HEAP_BASE: begin
						heap_top_q <= cfg_data[ADDR_W-1:0] & ~ADDR_W'(CLASS_STEP - 1);
					end
					REG_HEAP_LIMIT: heap_limit_q <= cfg_data[ADDR_W-1:0];
					default: begin
					end
				endcase
			end
			if (heap_we) heap_top_q <= heap_next;
		end
	end

	// a push never takes a counter past the class depth
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_we |-> (fill_wdata <= FILL_W'(CLASS_DEPTH)))
		else $error("fill counter written past class depth");

	// a stack read is issued only for a non-empty bin and is followed by its pop cycle
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		stk_re |-> ((fill_rd != '0) && !stk_we) ##1 (state_q == S_POP))
		else $error("stack read without a held entry");

	// a carve never moves the pointer past the heap limit
	a_carve_in_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(heap_we && !cfg_fire) |=> (heap_top_q <= heap_limit_q))
		else $error("heap pointer past limit after carve");

	// the output register is loaded only from the final state with room for it
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		($rose(rsp_valid_q)) |-> ($past(state_q) == S_OUT))
		else $error("result registered outside the output state");

endmodule

// File: hw/rtl/scfl_decode.sv
// ----------------------------------------------------------------------------
// scfl_decode
// Request decode: chunk sizing, mapping checks, cookie checks, class select.
// ----------------------------------------------------------------------------
module scfl_decode (
	input  scfl_pkg::req_t          req,
	input  logic [63:0]             secret_key,
	output scfl_pkg::dec_t          dec
);
	import scfl_pkg::*;

	logic [CALC_W-1:0] chunk_raw;
	logic [CALC_W-1:0] chunk;
	logic [CALC_W-1:0] pages;
	logic [WORD_W-1:0] size;

	always_comb begin
		chunk_raw = ((CALC_W'(req.request_bytes) + CALC_W'(CLASS_STEP - 1))
			& ~CALC_W'(CLASS_STEP - 1)) + CALC_W'(HDR_BYTES);
		chunk = (chunk_raw < CALC_W'(MIN_CHUNK)) ? CALC_W'(MIN_CHUNK) : chunk_raw;
		pages = (chunk + CALC_W'(HDR_BYTES + PAGE_BYTES - 1)) & ~CALC_W'(PAGE_BYTES - 1);
		size  = req.header_word & ~FLAG_BITS;
	end

	always_comb begin
		dec            = '0;
		dec.op         = OP_DONE;
		dec.res.status = ST_UNSUP;
		dec.addr       = req.user_address;
		if (!req.func) begin
			if (pages > CALC_W'(MAP_LIMIT_BYTES)) begin
				// mapping size must fit the map_bytes field
				if (|pages[CALC_W-1:MAP_W]) begin
					dec.res.status = ST_UNSUP;
				end else begin
					dec.res.status        = ST_MAP;
					dec.res.map_bytes     = pages[MAP_W-1:0];
					dec.res.size_word_out = WORD_W'(pages) | MAPPED_BIT;
					dec.res.cookie_out    = secret_key ^ WORD_W'(pages);
				end
			end else if (chunk <= CALC_W'(LARGEST_CLASS)) begin
				dec.op    = OP_POP;
				dec.chunk = chunk[CHUNK_W-1:0];
				dec.cls   = CLS_W'((chunk - CALC_W'(MIN_CHUNK)) >> $clog2(CLASS_STEP));
			end else begin
				dec.res.status = ST_UNSUP;
			end
		end else begin
			if (req.user_address == '0) begin
				dec.res.status = ST_NULL;
			end else if (|(req.header_word & MAPPED_BIT)) begin
				if (((secret_key ^ size) != req.cookie_word) || (|size[WORD_W-1:MAP_W])) begin
					dec.res.status = ST_BADCOOKIE;
				end else begin
					dec.res.status    = ST_UNMAP;
					dec.res.map_bytes = size[MAP_W-1:0];
				end
			end else if ((size >= WORD_W'(MIN_CHUNK)) && (size <= WORD_W'(LARGEST_CLASS))) begin
				dec.op  = OP_PUSH;
				dec.cls = CLS_W'((size - WORD_W'(MIN_CHUNK)) >> $clog2(CLASS_STEP));
			end else begin
				dec.res.status = ST_DROP;
			end
		end
	end

endmodule

// File: hw/rtl/scfl_fill_table.sv
// ----------------------------------------------------------------------------
// scfl_fill_table
// Per-class fill counters in a synchronous memory; valid bits give reset zero.
// ----------------------------------------------------------------------------
module scfl_fill_table (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         rd_en,
	input  logic [scfl_pkg::CLS_W-1:0]   rd_addr,
	output logic [scfl_pkg::FILL_W-1:0]  rd_data,
	input  logic                         wr_en,
	input  logic [scfl_pkg::CLS_W-1:0]   wr_addr,
	input  logic [scfl_pkg::FILL_W-1:0]  wr_data
);
	import scfl_pkg::*;

	logic [FILL_W-1:0]       mem [SIZE_CLASSES];
	logic [SIZE_CLASSES-1:0] valid_q;
	logic [FILL_W-1:0]       rd_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// an entry never written reads as zero
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= valid_q[rd_addr] ? mem[rd_addr] : '0;
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: hw/rtl/scfl_stack_ram.sv
// ----------------------------------------------------------------------------
// scfl_stack_ram
// Bin stack storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module scfl_stack_ram (
	input  logic                           clk,
	input  logic                           wr_en,
	input  logic [scfl_pkg::STACK_AW-1:0]  wr_addr,
	input  logic [scfl_pkg::ADDR_W-1:0]    wr_data,
	input  logic                           rd_en,
	input  logic [scfl_pkg::STACK_AW-1:0]  rd_addr,
	output logic [scfl_pkg::ADDR_W-1:0]    rd_data
);
	import scfl_pkg::*;

	logic [ADDR_W-1:0] mem [STACK_DEPTH];
	logic [ADDR_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
